// ----- hdl/taylor_sine_of_phase_top_defines.svh -----
// assertion macros for the taylor sine block
`ifndef TAYLOR_SINE_OF_PHASE_TOP_DEFINES_SVH
`define TAYLOR_SINE_OF_PHASE_TOP_DEFINES_SVH
`ifndef SYNTHESIS
// check with reset masking
`define TSP_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("tsp check failed");
// check that also covers the reset period
`define TSP_ASSERT_RST(lbl, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("tsp reset check failed");
`else
`define TSP_ASSERT(lbl, prop)
`define TSP_ASSERT_RST(lbl, prop)
`endif
`endif

// ----- hdl/tsp_pkg.sv -----
package tsp_pkg;

    localparam int FRAC_BITS = 16;
    localparam int QSHIFT    = 30;
    localparam int QW        = 34;
    localparam int FW        = 18;
    localparam int YW        = FRAC_BITS + 1;
    localparam int QDEPTH    = 4;
    localparam int QAW       = $clog2(QDEPTH);
    localparam int QCW       = $clog2(QDEPTH + 1);

    typedef logic signed [QW-1:0] q_t;
    typedef logic signed [FW-1:0] field_t;
    typedef logic signed [YW-1:0] yp_t;

    // queue status seen by both sides
    typedef struct packed {
        logic           full;
        logic           nonempty;
        logic [QCW-1:0] level;
    } q_stat_t;

    // q.30 constants
    localparam q_t Q_ONE   = q_t'(64'sd1 <<< QSHIFT);
    localparam q_t PI_Q    = 34'sd3373259426;
    localparam q_t C_IF3   = 34'sd178956971;
    localparam q_t C_IF5   = 34'sd8947849;
    localparam q_t C_IF7   = 34'sd213044;
    localparam q_t C_IF9   = 34'sd2959;
    localparam q_t C_IF11  = 34'sd27;

    // additive terms of the later horner steps
    localparam q_t HORNER_ADD [4] = '{-C_IF7, C_IF5, -C_IF3, Q_ONE};

    // phase and output limits in field units
    localparam q_t ONE_F      = q_t'(64'sd1 <<< FRAC_BITS);
    localparam q_t NEG_ONE_F  = -ONE_F;
    localparam q_t HALF_F     = ONE_F >>> 1;
    localparam q_t NEG_HALF_F = -HALF_F;
    localparam q_t FIELD_MAX  = q_t'((64'sd1 <<< (FW - 1)) - 64'sd1);
    localparam q_t FIELD_MIN  = q_t'(-(64'sd1 <<< (FW - 1)));
    localparam q_t SAT_HI     = (ONE_F < FIELD_MAX) ? ONE_F : FIELD_MAX;
    localparam q_t SAT_LO     = (NEG_ONE_F > FIELD_MIN) ? NEG_ONE_F : FIELD_MIN;
    localparam q_t OUT_RND    = q_t'(64'sd1 <<< (QSHIFT - FRAC_BITS - 1));
    localparam logic signed [2*QW-1:0] MUL_RND =
        (2*QW)'(64'sd1 <<< (QSHIFT - 1));

    // q.30 product, rounded half up
    function automatic q_t mul_q(input q_t a, input q_t b);
        logic signed [2*QW-1:0] prod;
        prod = a * b;
        prod = prod + MUL_RND;
        return prod[QSHIFT +: QW];
    endfunction

endpackage

// ----- hdl/tsp_front.sv -----
module tsp_front (
    input  logic               phase_valid,
    input  tsp_pkg::field_t    phase_in,
    output logic               phase_stall,
    input  tsp_pkg::q_stat_t   q_stat,
    output logic               push,
    output tsp_pkg::yp_t       push_data
);

    tsp_pkg::q_t p;
    tsp_pkg::q_t f;

    always_comb
    begin
        // clamp to plus or minus one
        p = tsp_pkg::q_t'(phase_in);
        if (p > tsp_pkg::ONE_F)
        begin
            p = tsp_pkg::ONE_F;
        end
        if (p < tsp_pkg::NEG_ONE_F)
        begin
            p = tsp_pkg::NEG_ONE_F;
        end
        // fold into the quarter wave
        if (p > tsp_pkg::HALF_F)
        begin
            f = tsp_pkg::ONE_F - p;
        end
        else if (p < tsp_pkg::NEG_HALF_F)
        begin
            f = tsp_pkg::NEG_ONE_F - p;
        end
        else
        begin
            f = p;
        end
    end

    assign push_data   = f[tsp_pkg::YW-1:0];
    assign phase_stall = q_stat.full;
    assign push        = phase_valid && !q_stat.full;

endmodule

// ----- hdl/tsp_fifo.sv -----
module tsp_fifo (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  tsp_pkg::yp_t       push_data,
    input  logic               pop,
    output tsp_pkg::yp_t       head_data,
    output tsp_pkg::q_stat_t   q_stat
);

    tsp_pkg::yp_t                  mem_reg [tsp_pkg::QDEPTH];
    logic [tsp_pkg::QAW-1:0]       wr_ptr_reg;
    logic [tsp_pkg::QAW-1:0]       wr_ptr_next;
    logic [tsp_pkg::QAW-1:0]       rd_ptr_reg;
    logic [tsp_pkg::QAW-1:0]       rd_ptr_next;
    logic [tsp_pkg::QCW-1:0]       level_reg;
    logic [tsp_pkg::QCW-1:0]       level_next;
    logic                          do_push;
    logic                          do_pop;

    assign q_stat.full     = (level_reg == tsp_pkg::QCW'(tsp_pkg::QDEPTH));
    assign q_stat.nonempty = (level_reg != '0);
    assign q_stat.level    = level_reg;
    assign head_data       = mem_reg[rd_ptr_reg];

    assign do_push = push && !q_stat.full;
    assign do_pop  = pop && q_stat.nonempty;

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        level_next  = level_reg;
        if (do_push && !do_pop)
        begin
            level_next = level_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            level_next = level_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ----- hdl/tsp_back.sv -----
module tsp_back (
    input  logic               clk,
    input  logic               rst_n,
    input  tsp_pkg::q_stat_t   q_stat,
    input  tsp_pkg::yp_t       head_data,
    output logic               pop,
    output logic               sine_valid,
    output tsp_pkg::field_t    sine_out,
    input  logic               sine_stall
);

    logic            vld_reg  [1:9];
    logic            vld_next [1:9];
    tsp_pkg::q_t     x_reg    [1:7];
    tsp_pkg::q_t     x_next   [1:7];
    tsp_pkg::q_t     x2_reg   [2:6];
    tsp_pkg::q_t     x2_next  [2:6];
    tsp_pkg::q_t     v_reg    [3:7];
    tsp_pkg::q_t     v_next   [3:7];
    tsp_pkg::q_t     s_reg;
    tsp_pkg::q_t     s_next;
    tsp_pkg::field_t sine_reg;
    tsp_pkg::field_t sine_next;
    tsp_pkg::q_t     r;
    logic            adv;

    // whole pipeline moves unless the output is held
    assign adv        = !vld_reg[9] || !sine_stall;
    assign pop        = adv && q_stat.nonempty;
    assign sine_valid = vld_reg[9];
    assign sine_out   = sine_reg;

    always_comb
    begin
        vld_next[1] = q_stat.nonempty;
        for (int k = 2; k <= 9; k++)
        begin
            vld_next[k] = vld_reg[k-1];
        end

        // scale by pi
        x_next[1] = tsp_pkg::mul_q(
            tsp_pkg::q_t'(head_data) <<< (tsp_pkg::QSHIFT - tsp_pkg::FRAC_BITS),
            tsp_pkg::PI_Q);
        for (int k = 2; k <= 7; k++)
        begin
            x_next[k] = x_reg[k-1];
        end

        // square
        x2_next[2] = tsp_pkg::mul_q(x_reg[1], x_reg[1]);
        for (int k = 3; k <= 6; k++)
        begin
            x2_next[k] = x2_reg[k-1];
        end

        // horner steps, one multiply each
        v_next[3] = tsp_pkg::C_IF9 - tsp_pkg::mul_q(x2_reg[2], tsp_pkg::C_IF11);
        for (int k = 4; k <= 7; k++)
        begin
            v_next[k] = tsp_pkg::mul_q(x2_reg[k-1], v_reg[k-1])
                        + tsp_pkg::HORNER_ADD[k-4];
        end

        // final odd factor
        s_next = tsp_pkg::mul_q(x_reg[7], v_reg[7]);

        // round to field precision and saturate
        r = (s_reg + tsp_pkg::OUT_RND) >>> (tsp_pkg::QSHIFT - tsp_pkg::FRAC_BITS);
        if (r > tsp_pkg::SAT_HI)
        begin
            r = tsp_pkg::SAT_HI;
        end
        if (r < tsp_pkg::SAT_LO)
        begin
            r = tsp_pkg::SAT_LO;
        end
        sine_next = r[tsp_pkg::FW-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 1; k <= 9; k++)
            begin
                vld_reg[k] <= 1'b0;
            end
        end
        else if (adv)
        begin
            for (int k = 1; k <= 9; k++)
            begin
                vld_reg[k] <= vld_next[k];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            x_reg    <= x_next;
            x2_reg   <= x2_next;
            v_reg    <= v_next;
            s_reg    <= s_next;
            sine_reg <= sine_next;
        end
    end

endmodule

// ----- hdl/taylor_sine_of_phase_top.sv -----
// sine of a phase in half-cycle units, degree eleven taylor polynomial
// phase channel: phase_valid, phase_stall, phase_in (signed q2.16, 1.0 is pi)
// sine channel: sine_valid, sine_stall, sine_out (signed q2.16, clipped to +-1.0)
// a request moves when valid is high and stall is low at a rising clock edge
// the front clamps and folds the phase into [-0.5, 0.5] and writes a 4-entry queue
// the back is a 9-stage pipeline, one 34x34 multiply per stage but the last:
// pi scale, square, five horner steps, final x multiply, round and saturate
// throughput: one request per cycle while sine_out is not held by sine_stall
// when sine_stall holds a valid result the back pipeline freezes and the queue
// keeps taking requests; phase_stall rises once the queue holds 4 requests
// reset (rst_n low, asynchronous) empties the queue and clears all valids
// results come out in request order, one result per request
`include "taylor_sine_of_phase_top_defines.svh"

module taylor_sine_of_phase_top (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               phase_valid,
    output logic               phase_stall,
    input  tsp_pkg::field_t    phase_in,
    output logic               sine_valid,
    input  logic               sine_stall,
    output tsp_pkg::field_t    sine_out
);

    // queue status shared by front and back
    tsp_pkg::q_stat_t q_stat;
    logic             push;
    tsp_pkg::yp_t     push_data;
    logic             pop;
    tsp_pkg::yp_t     head_data;

    // front: clamp and fold
    tsp_front u_front (
        .phase_valid (phase_valid),
        .phase_in    (phase_in),
        .phase_stall (phase_stall),
        .q_stat      (q_stat),
        .push        (push),
        .push_data   (push_data)
    );

    // decoupling queue between the two sides
    tsp_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .head_data (head_data),
        .q_stat    (q_stat)
    );

    // back: polynomial pipeline and output register
    tsp_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_stat     (q_stat),
        .head_data  (head_data),
        .pop        (pop),
        .sine_valid (sine_valid),
        .sine_out   (sine_out),
        .sine_stall (sine_stall)
    );

    // result never leaves the saturation window
    `TSP_ASSERT(a_sine_range, sine_valid |-> (sine_out <= tsp_pkg::SAT_HI && sine_out >= tsp_pkg::SAT_LO))
    // queue level stays within its depth
    `TSP_ASSERT(a_queue_level, q_stat.level <= tsp_pkg::QCW'(tsp_pkg::QDEPTH))
    // an accepted request always lands in the queue
    `TSP_ASSERT(a_push_lands, (phase_valid && !phase_stall && !pop) |=> q_stat.nonempty)
    // nothing valid comes out of reset
    `TSP_ASSERT_RST(a_reset_idle, !rst_n |=> !sine_valid)

endmodule
